/* src/tdq_pkg.sv */
package tdq_pkg;

  // Default sizing
  localparam int DEPTH_DEF     = 64;
  localparam int ITEM_BITS_DEF = 32;

  // Fixed port field widths
  localparam int MODE_W = 2;
  localparam int ITEM_W = 32;
  localparam int LEN_W  = 7;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_APPEND  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PREPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEQUEUE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE  = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ITEM_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic              success;
    logic [ITEM_W-1:0] item_out;
    logic [LEN_W-1:0]  length;
  } rsp_t;

endpackage

/* src/token_deque_with_delete_core.sv */
// Append, prepend and failed requests give their result from the execute state; dequeue
// goes on through a read state, and delete walks every held entry through the slot RAM.
// A new transaction is taken in the cycle the result is shown, so the block takes no new
// request before it is through with the last; the delete walk sets how long it is busy.
// Reset (rst, synchronous) empties the queue; slot contents are not cleared.
// Results appear on result for one cycle with done high; the receiver cannot stall.
module token_deque_with_delete_core #(
  parameter int DEPTH     = tdq_pkg::DEPTH_DEF,
  parameter int ITEM_BITS = tdq_pkg::ITEM_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  tdq_pkg::req_t req,
  output logic          done,
  output tdq_pkg::rsp_t result
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = (ITEM_BITS < tdq_pkg::ITEM_W) ? ITEM_BITS : tdq_pkg::ITEM_W;
  localparam int SUM_W = AW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DQ   = 2'd2;
  localparam logic [1:0] S_DEL  = 2'd3;

  logic [1:0]                  state;
  logic [tdq_pkg::MODE_W-1:0]  mode;
  logic [SW-1:0]               tok;
  logic [AW-1:0]               head;
  logic [CW-1:0]               count;
  logic [AW-1:0]               rd_ptr;
  logic [AW-1:0]               wr_ptr;
  logic [CW-1:0]               del_idx;
  logic [CW-1:0]               kept;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [SW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [SW-1:0] ram_rdata;

  logic [SUM_W-1:0] tail_sum;
  logic [AW-1:0]    tail_pos;
  logic [AW-1:0]    head_dec;
  logic [AW-1:0]    head_inc;
  logic [AW-1:0]    rd_inc;
  logic [AW-1:0]    wr_inc;
  logic             not_full;
  logic             tok_zero;
  logic             keep_it;
  logic             del_last;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  // Pointer arithmetic
  always_comb begin
    tail_sum = SUM_W'(head) + SUM_W'(count);
    if (tail_sum >= SUM_W'(DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(DEPTH);
    end
    tail_pos = tail_sum[AW-1:0];
    head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
    head_inc = wrap_inc(head);
    rd_inc   = wrap_inc(rd_ptr);
    wr_inc   = wrap_inc(wr_ptr);
    not_full = (count != CW'(DEPTH));
    tok_zero = (tok == '0);
    keep_it  = (ram_rdata != tok);
    del_last = (del_idx == count - CW'(1));
  end

  // RAM port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_ptr;
    ram_wdata = ram_rdata;
    ram_raddr = (state == S_DEL) ? rd_ptr : head;
    unique case (state)
      S_EXEC: begin
        ram_wdata = tok;
        if (mode == tdq_pkg::MODE_APPEND) begin
          ram_we    = !tok_zero && not_full;
          ram_waddr = tail_pos;
        end else if (mode == tdq_pkg::MODE_PREPEND) begin
          ram_we    = !tok_zero && not_full;
          ram_waddr = head_dec;
        end
      end
      S_DEL: begin
        ram_we = keep_it;
      end
      default: begin
      end
    endcase
  end

  tdq_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy = (state != S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            mode  <= req.mode;
            tok   <= req.item_value[SW-1:0];
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          result.item_out <= '0;
          unique case (mode)
            tdq_pkg::MODE_APPEND, tdq_pkg::MODE_PREPEND: begin
              result.success <= !tok_zero && not_full;
              result.length  <= tdq_pkg::LEN_W'(count);
              if (!tok_zero && not_full) begin
                count          <= count + CW'(1);
                result.length  <= tdq_pkg::LEN_W'(count + CW'(1));
                if (mode == tdq_pkg::MODE_PREPEND) begin
                  head <= head_dec;
                end
              end
              done  <= 1'b1;
              state <= S_IDLE;
            end
            tdq_pkg::MODE_DEQUEUE: begin
              if (count == '0) begin
                result.success <= 1'b0;
                result.length  <= '0;
                done           <= 1'b1;
                state          <= S_IDLE;
              end else begin
                state <= S_DQ;
              end
            end
            default: begin
              // delete: empty queue or null token finishes at once
              if (tok_zero || count == '0) begin
                result.success <= !tok_zero;
                result.length  <= tdq_pkg::LEN_W'(count);
                done           <= 1'b1;
                state          <= S_IDLE;
              end else begin
                rd_ptr  <= head_inc;
                wr_ptr  <= head;
                del_idx <= '0;
                kept    <= '0;
                state   <= S_DEL;
              end
            end
          endcase
        end
        S_DQ: begin
          result.success  <= 1'b1;
          result.item_out <= tdq_pkg::ITEM_W'(ram_rdata);
          result.length   <= tdq_pkg::LEN_W'(count - CW'(1));
          head            <= head_inc;
          count           <= count - CW'(1);
          done            <= 1'b1;
          state           <= S_IDLE;
        end
        default: begin
          // delete walk: read ahead one slot, compact kept entries behind it
          rd_ptr  <= rd_inc;
          del_idx <= del_idx + CW'(1);
          if (keep_it) begin
            wr_ptr <= wr_inc;
            kept   <= kept + CW'(1);
          end
          if (del_last) begin
            count          <= kept + CW'(keep_it);
            result.success <= 1'b1;
            result.length  <= tdq_pkg::LEN_W'(kept + CW'(keep_it));
            done           <= 1'b1;
            state          <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) != S_IDLE))
    else $error("result without a transaction in progress");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_EXEC))
    else $error("accepted transaction not executed");

  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEL) |-> (kept <= del_idx && del_idx < count))
    else $error("delete walk indices out of order");

  a_len_matches: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.length == tdq_pkg::LEN_W'(count)))
    else $error("reported length differs from entry count");

endmodule

/* src/tdq_ram.sv */
module tdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* test/tb_token_deque_with_delete_core.sv */
`timescale 1ns / 1ps

module tb_token_deque_with_delete_core;

  localparam int QDEPTH     = tdq_pkg::DEPTH_DEF;
  localparam int WDOG_LIMIT = 4000;
  localparam int SEG_ITEMS  = 64;
  localparam int MAX_SHOWN  = 10;

  // Mix of requests within one random segment
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  // One row of the directed table; rsp only used where typed is set
  typedef struct {
    logic [tdq_pkg::MODE_W-1:0] mode;
    logic [tdq_pkg::ITEM_W-1:0] value;
    bit                         typed;
    tdq_pkg::rsp_t              rsp;
  } dir_row_t;

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  tdq_pkg::req_t req;
  logic          done;
  tdq_pkg::rsp_t result;

  // Deque shadow state
  logic [tdq_pkg::ITEM_W-1:0] dq_slot [QDEPTH];
  int                         dq_head;
  int                         dq_count;

  tdq_pkg::rsp_t want_q [$];
  int            send_idle_pct;
  int            n_sent;
  int            n_checked;
  int            n_bad;
  int            n_full_rej;
  int            n_empty_deq;
  int            n_del_hits;
  int            wdog;
  logic [31:0]   tok_pool [4];

  dir_row_t dir_tab [23] = '{
    '{tdq_pkg::MODE_DEQUEUE, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 7'd0}},
    '{tdq_pkg::MODE_APPEND,  32'h0000_0000, 1'b1, '{1'b0, 32'h0, 7'd0}},
    '{tdq_pkg::MODE_PREPEND, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 7'd0}},
    '{tdq_pkg::MODE_DELETE,  32'h0000_0000, 1'b1, '{1'b0, 32'h0, 7'd0}},
    '{tdq_pkg::MODE_DELETE,  32'h0000_0005, 1'b1, '{1'b1, 32'h0, 7'd0}},
    '{tdq_pkg::MODE_APPEND,  32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0, 7'd1}},
    '{tdq_pkg::MODE_PREPEND, 32'h0000_0001, 1'b1, '{1'b1, 32'h0, 7'd2}},
    '{tdq_pkg::MODE_DEQUEUE, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h1, 7'd1}},
    '{tdq_pkg::MODE_DEQUEUE, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF, 7'd0}},
    '{tdq_pkg::MODE_APPEND,  32'h0000_0007, 1'b0, '0},
    '{tdq_pkg::MODE_PREPEND, 32'h0000_0007, 1'b0, '0},
    '{tdq_pkg::MODE_APPEND,  32'h0000_0009, 1'b0, '0},
    '{tdq_pkg::MODE_APPEND,  32'h0000_0007, 1'b0, '0},
    '{tdq_pkg::MODE_PREPEND, 32'h8000_0000, 1'b0, '0},
    '{tdq_pkg::MODE_DELETE,  32'h0000_0007, 1'b0, '0},
    '{tdq_pkg::MODE_DELETE,  32'h0000_0003, 1'b0, '0},
    '{tdq_pkg::MODE_DEQUEUE, 32'h1234_5678, 1'b0, '0},
    '{tdq_pkg::MODE_DEQUEUE, 32'h0000_0000, 1'b0, '0},
    '{tdq_pkg::MODE_DEQUEUE, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 7'd0}},
    '{tdq_pkg::MODE_PREPEND, 32'hAAAA_AAAA, 1'b0, '0},
    '{tdq_pkg::MODE_APPEND,  32'h5555_5555, 1'b0, '0},
    '{tdq_pkg::MODE_DELETE,  32'hAAAA_AAAA, 1'b0, '0},
    '{tdq_pkg::MODE_DELETE,  32'h5555_5555, 1'b0, '0}
  };

  token_deque_with_delete_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one request to the shadow deque and returns the result it gives
  function automatic tdq_pkg::rsp_t apply_to_deque(tdq_pkg::req_t r);
    tdq_pkg::rsp_t o;
    logic [31:0]   v;
    int            kept;
    o = '0;
    case (r.mode)
      tdq_pkg::MODE_APPEND, tdq_pkg::MODE_PREPEND: begin
        if (r.item_value != '0 && dq_count >= QDEPTH) n_full_rej++;
        if (r.item_value != '0 && dq_count < QDEPTH) begin
          if (r.mode == tdq_pkg::MODE_APPEND) begin
            dq_slot[(dq_head + dq_count) % QDEPTH] = r.item_value;
          end else begin
            dq_head = (dq_head + QDEPTH - 1) % QDEPTH;
            dq_slot[dq_head] = r.item_value;
          end
          dq_count++;
          o.success = 1'b1;
        end
      end
      tdq_pkg::MODE_DEQUEUE: begin
        if (dq_count > 0) begin
          o.item_out = dq_slot[dq_head];
          dq_head = (dq_head + 1) % QDEPTH;
          dq_count--;
          o.success = 1'b1;
        end else begin
          n_empty_deq++;
        end
      end
      default: begin
        // delete: compact survivors towards the head, order kept
        if (r.item_value != '0) begin
          kept = 0;
          for (int i = 0; i < dq_count; i++) begin
            v = dq_slot[(dq_head + i) % QDEPTH];
            if (v != r.item_value) begin
              dq_slot[(dq_head + kept) % QDEPTH] = v;
              kept++;
            end
          end
          if (kept < dq_count) n_del_hits++;
          dq_count = kept;
          o.success = 1'b1;
        end
      end
    endcase
    o.length = tdq_pkg::LEN_W'(dq_count);
    return o;
  endfunction

  // Offers one transaction, with random sender gaps, and records its expected result
  task automatic issue_req(input logic [tdq_pkg::MODE_W-1:0] m,
                           input logic [tdq_pkg::ITEM_W-1:0] v,
                           input bit typed, input tdq_pkg::rsp_t typed_rsp);
    tdq_pkg::req_t r;
    tdq_pkg::rsp_t p;
    r.mode       = m;
    r.item_value = v;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    p = apply_to_deque(r);
    want_q.push_back(typed ? typed_rsp : p);
    n_sent++;
  endtask

  // Holds off the sender until every outstanding result has arrived
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (want_q.size() != 0);
  endtask

  // Picks a token: mostly from a small pool so that deletes find matches
  function automatic logic [31:0] pick_token(int pool_pct);
    int r;
    r = $urandom_range(99);
    if (r < 4) return '0;
    if (r < pool_pct) return tok_pool[$urandom_range(3)];
    return $urandom;
  endfunction

  // Result checker
  always @(posedge clk) begin
    tdq_pkg::rsp_t w;
    if (!rst && done) begin
      if (want_q.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_SHOWN)
          $display("unexpected result: success=%0b item_out=%h length=%0d",
                   result.success, result.item_out, result.length);
      end else begin
        w = want_q.pop_front();
        n_checked++;
        if (result.success !== w.success || result.item_out !== w.item_out ||
            result.length !== w.length) begin
          n_bad++;
          if (n_bad <= MAX_SHOWN)
            $display("mismatch on result %0d: exp %0b/%h/%0d got %0b/%h/%0d", n_checked,
                     w.success, w.item_out, w.length,
                     result.success, result.item_out, result.length);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
        $display("timeout: no progress for %0d cycles", WDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    mix_t        plan [6];
    int          idle_sets [3];
    int          r;
    logic [1:0]  m;
    logic [31:0] v;

    plan      = '{MIX_FILL, MIX_FILL, MIX_EVEN, MIX_DRAIN, MIX_DRAIN, MIX_EVEN};
    idle_sets = '{18, 53, 0};
    n_sent = 0; n_checked = 0; n_bad = 0;
    n_full_rej = 0; n_empty_deq = 0; n_del_hits = 0;
    dq_head = 0; dq_count = 0;
    send_idle_pct = 0;
    rst   <= 1'b1;
    start <= 1'b0;
    req   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    send_idle_pct = 18;
    foreach (dir_tab[i])
      issue_req(dir_tab[i].mode, dir_tab[i].value, dir_tab[i].typed, dir_tab[i].rsp);
    wait_drained();

    // Random part: three sender idling regimes, each a run of biased segments
    foreach (idle_sets[k]) begin
      send_idle_pct = idle_sets[k];
      foreach (plan[s]) begin
        foreach (tok_pool[j]) tok_pool[j] = $urandom_range(15, 1) << $urandom_range(28);
        for (int n = 0; n < SEG_ITEMS; n++) begin
          r = $urandom_range(99);
          case (plan[s])
            MIX_FILL:  m = r < 40 ? tdq_pkg::MODE_APPEND : r < 78 ? tdq_pkg::MODE_PREPEND :
                           r < 97 ? tdq_pkg::MODE_DEQUEUE : tdq_pkg::MODE_DELETE;
            MIX_DRAIN: m = r < 10 ? tdq_pkg::MODE_APPEND : r < 20 ? tdq_pkg::MODE_PREPEND :
                           r < 90 ? tdq_pkg::MODE_DEQUEUE : tdq_pkg::MODE_DELETE;
            default:   m = r < 30 ? tdq_pkg::MODE_APPEND : r < 55 ? tdq_pkg::MODE_PREPEND :
                           r < 80 ? tdq_pkg::MODE_DEQUEUE : tdq_pkg::MODE_DELETE;
          endcase
          v = pick_token(m == tdq_pkg::MODE_DELETE ? 85 : 55);
          issue_req(m, v, 1'b0, '0);
        end
        if (s == 2) wait_drained();
      end
      wait_drained();
    end

    // Let any late or spurious result show up
    start <= 1'b0;
    repeat (QDEPTH + 8) @(posedge clk);

    $display("%0d transactions sent, %0d results checked, %0d mismatches", n_sent, n_checked,
             n_bad);
    $display("pushes refused when full: %0d, dequeues on empty: %0d, deletes that hit: %0d",
             n_full_rej, n_empty_deq, n_del_hits);
    if (n_bad == 0 && want_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
